// ===== src/cmfd_pkg.sv =====
// Package for the CRC-checked measurement frame decoder.
// Holds frame constants, register indexes, result codes, shared structs and
// the CRC-8 byte update; it depends on nothing.
package cmfd_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int POS_W       = 4;
    localparam int WORD_COUNT  = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ALL       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_CO2     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_STATUS = 2'd2;

    typedef enum logic [1:0] {
        RES_OK     = 2'd0,
        RES_BUS    = 2'd1,
        RES_CRC    = 2'd2,
        RES_SENSOR = 2'd3
    } result_code_t;

    typedef struct packed {
        logic        check_all;
        logic [15:0] invalid_co2;
        logic [15:0] expected_status;
    } cfg_t;

    typedef struct packed {
        result_code_t status;
        logic [15:0]  co2;
        logic [15:0]  temperature;
        logic [15:0]  humidity;
        logic [15:0]  stat_word;
    } result_t;

    // MSB-first CRC-8 over one byte, no reflection, no final xor.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== src/cmfd_frame_core.sv =====
// Frame tracking for the measurement decoder: byte position, running CRC,
// captured words and the result of a finished frame.
// Depends on cmfd_pkg.
module cmfd_frame_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              bus_fail,
    input  cmfd_pkg::cfg_t    cfg,
    output logic              push,
    output cmfd_pkg::result_t result
);

    logic [cmfd_pkg::POS_W-1:0] pos_reg;
    logic [1:0]                 phase_reg;
    logic [1:0]                 word_reg;
    logic                       crc_failed_reg;
    logic [7:0]                 crc_reg;
    logic [7:0]                 high_reg;
    logic [15:0]                words_reg [cmfd_pkg::WORD_COUNT];

    logic                       first;
    logic                       last;
    logic                       checked;
    logic [7:0]                 crc_next;
    logic                       crc_failed_next;
    logic [15:0]                words_next [cmfd_pkg::WORD_COUNT];

    always_comb
    begin
        first    = (pos_reg == '0);
        last     = (pos_reg >= cmfd_pkg::LAST_POS);
        crc_next = cmfd_pkg::crc8_update((phase_reg == 2'd0) ? cmfd_pkg::CRC_INIT : crc_reg,
                                         data_byte);

        // Words a frame has not reached yet read as zero.
        for (int i = 0; i < cmfd_pkg::WORD_COUNT; i++)
        begin
            words_next[i] = first ? 16'h0000 : words_reg[i];
        end
        if (phase_reg == 2'd1)
        begin
            words_next[word_reg] = {high_reg, data_byte};
        end

        checked = cfg.check_all || (word_reg == 2'd0) || (word_reg == 2'd3);
        crc_failed_next = (!first && crc_failed_reg)
                          || ((phase_reg == 2'd2) && checked && (crc_next != 8'h00));

        push = fire && (bus_fail || last);

        if (bus_fail)
        begin
            result.status      = cmfd_pkg::RES_BUS;
            result.co2         = cfg.invalid_co2;
            result.temperature = 16'h0000;
            result.humidity    = 16'h0000;
            result.stat_word   = 16'h0000;
        end
        else
        begin
            result.temperature = words_next[1];
            result.humidity    = words_next[2];
            result.stat_word   = words_next[3];
            // A CRC error outranks a sensor status failure.
            priority if (crc_failed_next)
            begin
                result.status = cmfd_pkg::RES_CRC;
                result.co2    = cfg.invalid_co2;
            end
            else if (words_next[3] != cfg.expected_status)
            begin
                result.status = cmfd_pkg::RES_SENSOR;
                result.co2    = cfg.invalid_co2;
            end
            else
            begin
                result.status = cmfd_pkg::RES_OK;
                result.co2    = words_next[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            phase_reg      <= 2'd0;
            word_reg       <= 2'd0;
            crc_failed_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (bus_fail || last)
            begin
                pos_reg        <= '0;
                phase_reg      <= 2'd0;
                word_reg       <= 2'd0;
                crc_failed_reg <= 1'b0;
            end
            else
            begin
                pos_reg        <= pos_reg + 1'b1;
                phase_reg      <= (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
                word_reg       <= (phase_reg == 2'd2) ? word_reg + 2'd1 : word_reg;
                crc_failed_reg <= crc_failed_next;
            end
        end
    end

    // Payload state is rewritten before it is read in every frame.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            crc_reg <= crc_next;
            if (phase_reg == 2'd0)
            begin
                high_reg <= data_byte;
            end
            for (int i = 0; i < cmfd_pkg::WORD_COUNT; i++)
            begin
                words_reg[i] <= words_next[i];
            end
        end
    end

endmodule

// ===== src/cmfd_out_skid.sv =====
// Two-entry result buffer: an output register backed by one skid register,
// so a new result can be taken while the previous one is still held.
// Depends on cmfd_pkg.
module cmfd_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cmfd_pkg::result_t din,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              full,
    output cmfd_pkg::result_t dout
);

    logic              head_valid_reg;
    logic              skid_valid_reg;
    cmfd_pkg::result_t head_reg;
    cmfd_pkg::result_t skid_reg;
    logic              head_free;

    assign head_free = !head_valid_reg || !out_stall;
    assign out_valid = head_valid_reg;
    assign full      = skid_valid_reg;
    assign dout      = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (head_free)
        begin
            if (skid_valid_reg)
            begin
                head_valid_reg <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                head_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_free)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                skid_reg <= din;
            end
            else
            begin
                head_reg <= din;
            end
        end
        else if (push)
        begin
            skid_reg <= din;
        end
    end

endmodule

// ===== src/crc_checked_measurement_frame_decoder.sv =====
// Top level of the CRC-checked measurement frame decoder: configuration
// registers, frame core and result buffer.
// Depends on cmfd_pkg, cmfd_frame_core and cmfd_out_skid.
//
//   Channel   Handshake             Payload
//   -------   -------------------   ------------------------------------------
//   cfg       cfg_write             cfg_index, cfg_data
//   in        in_valid / in_stall   data_byte, bus_fail
//   out       out_valid / out_stall result_status, co2_ppm, temperature_raw,
//                                   humidity_raw, sensor_status_word
//
// One byte is taken per cycle while in_stall is low; the CRC update, word
// capture and result decision all finish in the cycle of the transfer. A frame
// of 12 bytes has its result loaded into the output register as its last byte
// is taken, unless an earlier result is still held by out_stall; then it waits
// in the skid register. in_stall rises only when both the output register and
// the skid register hold results. Reset clears the frame position and the
// result buffer and loads the register defaults.
module crc_checked_measurement_frame_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cmfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cmfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     data_byte,
    input  logic                           bus_fail,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     result_status,
    output logic [15:0]                    co2_ppm,
    output logic [15:0]                    temperature_raw,
    output logic [15:0]                    humidity_raw,
    output logic [15:0]                    sensor_status_word
);

    cmfd_pkg::cfg_t    cfg_reg;
    cmfd_pkg::result_t core_result;
    cmfd_pkg::result_t out_result;
    logic              fire;
    logic              push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_all       <= 1'b1;
            cfg_reg.invalid_co2     <= 16'hFFFF;
            cfg_reg.expected_status <= 16'h0004;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cmfd_pkg::CFG_CHECK_ALL:       cfg_reg.check_all       <= cfg_data[0];
                cmfd_pkg::CFG_INVALID_CO2:     cfg_reg.invalid_co2     <= cfg_data;
                cmfd_pkg::CFG_EXPECTED_STATUS: cfg_reg.expected_status <= cfg_data;
                default:
                begin
                    // Writes to an unknown index are dropped.
                end
            endcase
        end
    end

    assign fire = in_valid && !in_stall;

    cmfd_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (data_byte),
        .bus_fail  (bus_fail),
        .cfg       (cfg_reg),
        .push      (push),
        .result    (core_result)
    );

    cmfd_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (core_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .full      (in_stall),
        .dout      (out_result)
    );

    assign result_status      = 2'(out_result.status);
    assign co2_ppm            = out_result.co2;
    assign temperature_raw    = out_result.temperature;
    assign humidity_raw       = out_result.humidity;
    assign sensor_status_word = out_result.stat_word;

endmodule

// ===== src/cmfd_checker.sv =====
// Port-level checks for the measurement frame decoder, bound to the top level.
// Depends on cmfd_pkg and crc_checked_measurement_frame_decoder.
module cmfd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_write,
    input logic [cmfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [cmfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [7:0]                      data_byte,
    input logic                            bus_fail,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [1:0]                      result_status,
    input logic [15:0]                     co2_ppm,
    input logic [15:0]                     temperature_raw,
    input logic [15:0]                     humidity_raw,
    input logic [15:0]                     sensor_status_word
);

    // A held result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(result_status) && $stable(co2_ppm)
            && $stable(temperature_raw) && $stable(humidity_raw)
            && $stable(sensor_status_word)))
    else $error("output payload changed while stalled");

    // The input side is held off only when results are already waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
    else $error("input stalled with no pending result");

    // After a bus failure transfer, out_valid is always high on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && bus_fail) |=> out_valid)
    else $error("bus failure transfer gave no result");

    // Bus error results carry zero words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_status == 2'(cmfd_pkg::RES_BUS)))
            |-> ((temperature_raw == 16'h0000) && (humidity_raw == 16'h0000)
                 && (sensor_status_word == 16'h0000)))
    else $error("bus error result with nonzero words");

endmodule

bind crc_checked_measurement_frame_decoder cmfd_checker u_cmfd_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for crc_checked_measurement_frame_decoder.
// Depends on cmfd_pkg and the decoder RTL; a scoreboard class predicts each
// frame result from the accepted bytes and checks the results as they leave.
module testbench;

    localparam logic [cmfd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 195;

    class frame_result_tracker;
        bit                 check_all;
        logic [15:0]        bad_co2;
        logic [15:0]        good_status;
        int                 frame_pos;
        logic [7:0]         word_crc;
        logic [7:0]         high_byte;
        logic [15:0]        words [4];
        bit                 crc_error;
        cmfd_pkg::result_t  pending_results [$];
        int                 errors;

        function new();
            check_all   = 1'b1;
            bad_co2     = 16'hFFFF;
            good_status = 16'h0004;
            words       = '{default: '0};
            errors      = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            frame_pos = 0;
            word_crc  = cmfd_pkg::CRC_INIT;
            high_byte = 8'h00;
            crc_error = 1'b0;
        endfunction

        // Bit-serial form of the CRC-8 update, most significant bit first.
        function logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            logic       feedback;
            c = crc;
            for (int i = 7; i >= 0; i--)
            begin
                feedback = c[7] ^ b[i];
                c = {c[6:0], 1'b0} ^ (feedback ? cmfd_pkg::CRC_POLY : 8'h00);
            end
            return c;
        endfunction

        function void set_register(logic [cmfd_pkg::CFG_IDX_W-1:0] idx,
                                   logic [cmfd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                cmfd_pkg::CFG_CHECK_ALL:       check_all = data[0];
                cmfd_pkg::CFG_INVALID_CO2:     bad_co2 = data;
                cmfd_pkg::CFG_EXPECTED_STATUS: good_status = data;
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] b, logic fail);
            cmfd_pkg::result_t r;
            int                pos;
            int                w;
            if (fail)
            begin
                r.status      = cmfd_pkg::RES_BUS;
                r.co2         = bad_co2;
                r.temperature = 16'h0000;
                r.humidity    = 16'h0000;
                r.stat_word   = 16'h0000;
                pending_results.push_back(r);
                restart_frame();
                words = '{default: '0};
                return;
            end
            pos = (frame_pos >= cmfd_pkg::FRAME_BYTES) ? cmfd_pkg::FRAME_BYTES - 1 : frame_pos;
            if (pos == 0)
            begin
                words     = '{default: '0};
                crc_error = 1'b0;
            end
            w = pos / 3;
            case (pos % 3)
                0:
                begin
                    word_crc  = crc_byte(cmfd_pkg::CRC_INIT, b);
                    high_byte = b;
                end
                1:
                begin
                    word_crc = crc_byte(word_crc, b);
                    words[w] = {high_byte, b};
                end
                default:
                begin
                    word_crc = crc_byte(word_crc, b);
                    if ((check_all || w == 0 || w == 3) && word_crc != 8'h00)
                        crc_error = 1'b1;
                end
            endcase
            if (pos + 1 < cmfd_pkg::FRAME_BYTES)
            begin
                frame_pos = pos + 1;
                return;
            end
            r.temperature = words[1];
            r.humidity    = words[2];
            r.stat_word   = words[3];
            if (crc_error)
            begin
                r.status = cmfd_pkg::RES_CRC;
                r.co2    = bad_co2;
            end
            else if (words[3] != good_status)
            begin
                r.status = cmfd_pkg::RES_SENSOR;
                r.co2    = bad_co2;
            end
            else
            begin
                r.status = cmfd_pkg::RES_OK;
                r.co2    = words[0];
            end
            pending_results.push_back(r);
            restart_frame();
        endfunction

        function bit field_ok(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_result(cmfd_pkg::result_t got);
            cmfd_pkg::result_t want;
            bit                ok;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status %0d co2 %h",
                         $time, got.status, got.co2);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            ok = 1'b1;
            if (want.status !== got.status)
            begin
                $display("%0t: result_status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                ok = 1'b0;
            end
            ok &= field_ok("co2_ppm", want.co2, got.co2);
            ok &= field_ok("temperature_raw", want.temperature, got.temperature);
            ok &= field_ok("humidity_raw", want.humidity, got.humidity);
            ok &= field_ok("sensor_status_word", want.stat_word, got.stat_word);
            if (!ok)
                errors++;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [cmfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cmfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [7:0]                      data_byte = 8'h00;
    logic                            bus_fail = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [1:0]                      result_status;
    logic [15:0]                     co2_ppm;
    logic [15:0]                     temperature_raw;
    logic [15:0]                     humidity_raw;
    logic [15:0]                     sensor_status_word;

    frame_result_tracker tracker;
    cmfd_pkg::result_t   seen_result;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  frame_fill = 0;
    int                  bytes_sent = 0;
    int                  cycle_count = 0;

    crc_checked_measurement_frame_decoder u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .data_byte          (data_byte),
        .bus_fail           (bus_fail),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .result_status      (result_status),
        .co2_ppm            (co2_ppm),
        .temperature_raw    (temperature_raw),
        .humidity_raw       (humidity_raw),
        .sensor_status_word (sensor_status_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tracker.take_byte(data_byte, bus_fail);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_result.status      = cmfd_pkg::result_code_t'(result_status);
            seen_result.co2         = co2_ppm;
            seen_result.temperature = temperature_raw;
            seen_result.humidity    = humidity_raw;
            seen_result.stat_word   = sensor_status_word;
            tracker.check_result(seen_result);
        end
    end

    task automatic write_register(input logic [cmfd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [cmfd_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.set_register(idx, data);
    endtask

    // The write to the unused index must leave every register untouched.
    task automatic write_settings(input bit check, input logic [15:0] invalid_co2,
                                  input logic [15:0] status);
        write_register(cmfd_pkg::CFG_CHECK_ALL, {15'd0, check});
        write_register(cmfd_pkg::CFG_INVALID_CO2, invalid_co2);
        write_register(cmfd_pkg::CFG_EXPECTED_STATUS, status);
        write_register(CFG_UNUSED, 16'($urandom));
        cfg_write <= 1'b0;
    endtask

    task automatic send_item(input logic [7:0] b, input logic fail);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        bus_fail  <= fail;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frame_fill = fail ? 0 : (frame_fill + 1) % cmfd_pkg::FRAME_BYTES;
        bytes_sent++;
    endtask

    // Sends one response; bad_word < 0 keeps every CRC intact, and a cut_at
    // below the frame length ends the transfer early with a bus failure.
    task automatic send_words(input logic [15:0] co2, input logic [15:0] temp,
                              input logic [15:0] hum, input logic [15:0] status,
                              input int bad_word, input int cut_at);
        logic [15:0] values [4];
        logic [7:0]  frame_bytes [cmfd_pkg::FRAME_BYTES];
        int          w;
        int          i;
        values = '{co2, temp, hum, status};
        for (w = 0; w < 4; w++)
        begin
            frame_bytes[3*w]     = values[w][15:8];
            frame_bytes[3*w + 1] = values[w][7:0];
            frame_bytes[3*w + 2] =
                tracker.crc_byte(tracker.crc_byte(cmfd_pkg::CRC_INIT, values[w][15:8]),
                                 values[w][7:0]);
            if (w == bad_word)
                frame_bytes[3*w + $urandom_range(2)] ^= 8'($urandom_range(255, 1));
        end
        for (i = 0; i < cut_at && i < cmfd_pkg::FRAME_BYTES; i++)
            send_item(frame_bytes[i], 1'b0);
        if (cut_at < cmfd_pkg::FRAME_BYTES)
            send_item(8'($urandom), 1'b1);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame();
        logic [15:0] status;
        int          bad_word;
        int          cut_at;
        status   = ($urandom_range(99) < 65) ? tracker.good_status : pick_word();
        bad_word = ($urandom_range(99) < 20) ? int'($urandom_range(3)) : -1;
        cut_at   = ($urandom_range(99) < 6) ? int'($urandom_range(cmfd_pkg::FRAME_BYTES - 1))
                                            : cmfd_pkg::FRAME_BYTES;
        send_words(pick_word(), pick_word(), pick_word(), status, bad_word, cut_at);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    task automatic settle();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed responses, with bus failures and with stray bytes that
    // leave the decoder mid-frame until a failure or padding realigns it.
    task automatic run_traffic(input int count);
        int start;
        int roll;
        bit drained;
        start   = bytes_sent;
        drained = 1'b0;
        while (bytes_sent - start < count)
        begin
            if (!drained && bytes_sent - start >= count / 2 && frame_fill == 0)
            begin
                wait_for_results();
                drained = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 7)
                send_item(8'($urandom), 1'b0);
            else if (roll < 12)
                send_item(8'($urandom), 1'b1);
            else
            begin
                if (frame_fill != 0)
                begin
                    if ($urandom_range(1))
                        send_item(8'($urandom), 1'b1);
                    else
                        while (frame_fill != 0)
                            send_item(8'($urandom), 1'b0);
                end
                send_frame();
            end
        end
        while (frame_fill != 0)
            send_item(8'($urandom), 1'b0);
    endtask

    initial
    begin
        int phase;
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_settings(1'b1, 16'hFFFF, 16'h0004);

        // Good response with extreme words, then a CRC error on the
        // temperature word with a wrong status word, then a bus failure.
        send_words(16'hFFFF, 16'h0000, 16'h8001, 16'h0004, -1, cmfd_pkg::FRAME_BYTES);
        send_words(16'h0000, 16'hFFFF, 16'h7FFE, 16'hFFFF, 1, cmfd_pkg::FRAME_BYTES);
        send_item(8'hFF, 1'b1);

        for (phase = 0; phase < 4; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    write_settings(1'b1, 16'hFFFF, 16'h0004);
                end
                1:
                begin
                    send_idle_pct = 52;
                    stall_pct     = 0;
                    write_settings(1'b0, 16'h0000, 16'hFFFF);
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 52;
                    write_settings(1'b1, 16'($urandom), 16'h0000);
                end
                default:
                begin
                    send_idle_pct = 27;
                    stall_pct     = 27;
                    write_settings(1'b0, 16'($urandom), 16'($urandom));
                end
            endcase
            run_traffic(PHASE_ITEMS);
        end
        settle();

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
src/cmfd_pkg.sv
src/cmfd_frame_core.sv
src/cmfd_out_skid.sv
src/crc_checked_measurement_frame_decoder.sv
src/cmfd_checker.sv
tb/testbench.sv
